[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helpers used by the checker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is low
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// clocked property that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/ddsp_pkg.sv]
// ---------------------------------------------------------------------------
// ddsp_pkg
// Shared types and constants of the differential drive slew and PWM unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddsp_pkg;

  // request codes
  typedef enum logic [2:0] {
    REQ_DRIVE  = 3'd0,
    REQ_STOP   = 3'd1,
    REQ_ESTOP  = 3'd2,
    REQ_ENABLE = 3'd3,
    REQ_TICK   = 3'd4
  } req_type_e;

  // drive directions
  typedef enum logic [2:0] {
    DIR_FWD    = 3'd0,
    DIR_REV    = 3'd1,
    DIR_SPIN_L = 3'd2,
    DIR_SPIN_R = 3'd3,
    DIR_NONE   = 3'd4
  } drive_dir_e;

  // register map, word index
  localparam logic REG_RAMP_RATE = 1'b0;

  localparam int          DUTY_MAX_DEF  = 1023;
  localparam logic [16:0] RAMP_RATE_RST = 17'd7000;

  // full scale level in centi-percent
  localparam int LEVEL_FULL = 10000;

  // speed clamp in whole percent
  localparam logic [6:0] PCT_MAX = 7'd100;

  // largest useful slew step: a full swing from one end to the other
  localparam logic [14:0] STEP_MAX = 15'd20000;

  // x / 125 = (x * RECIP_125) >> RECIP_125_SHIFT, exact for x below 2**30
  localparam logic [30:0] RECIP_125       = 31'd1099511628;
  localparam int          RECIP_125_SHIFT = 37;

endpackage

[hdl/differential_drive_slew_pwm_unit.sv]
// ---------------------------------------------------------------------------
// differential_drive_slew_pwm_unit
// Throughput: one word per cycle when the result channel is not stalled;
// the target and level update is a single add and compare per track in one
// stage, the multiplies sit in stages of their own around it. Reset clears
// targets, levels, estop and all valids, and loads the ramp rate with
// 7000 centi-percent per second.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_slew_pwm_unit #(
  parameter int DUTY_MAX = ddsp_pkg::DUTY_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [2:0]         drive_dir_i,
  input  logic [6:0]         speed_pct_i,
  input  logic [15:0]        elapsed_ms_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         left_fwd_duty_o,
  output logic [9:0]         left_rev_duty_o,
  output logic [9:0]         right_fwd_duty_o,
  output logic [9:0]         right_rev_duty_o,
  output logic signed [14:0] left_now_o,
  output logic signed [14:0] right_now_o,
  output logic               estop_active_o
);

  // duty product width and the reciprocal for the divide by 10000
  localparam int PW   = $clog2(ddsp_pkg::LEVEL_FULL * DUTY_MAX
                               + ddsp_pkg::LEVEL_FULL / 2 + 1);
  localparam int K2   = PW + 6;
  localparam int PRW  = K2 + 16;
  localparam logic [63:0] RECIP_625 = ((64'd1 << K2) + 64'd624) / 64'd625;

  // register file
  logic [16:0] ramp_rate_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ddsp_pkg::REG_RAMP_RATE);
  assign prdata = (paddr[2] == ddsp_pkg::REG_RAMP_RATE) ? {15'd0, ramp_rate_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_rate_q <= ddsp_pkg::RAMP_RATE_RST;
    end else if (cfg_wr) begin
      ramp_rate_q <= pwdata[16:0];
    end
  end

  // stage valids and flow control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_v_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, out_rdy;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign rdy5    = !v5_q || out_rdy;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;

  assign in_stall_o  = !rdy1;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      v5_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q    <= in_valid_i;
      if (rdy2)    v2_q    <= v1_q;
      if (rdy3)    v3_q    <= v2_q;
      if (rdy4)    v4_q    <= v3_q;
      if (rdy5)    v5_q    <= v4_q;
      if (out_rdy) out_v_q <= v5_q;
    end
  end

  // stage 1: input word, rate times elapsed time
  logic [2:0]  req1_q, dir1_q;
  logic [6:0]  pct1_q;
  logic [15:0] ms1_q;
  logic [15:0] ms_eff;
  logic [32:0] prod_d;

  assign ms_eff = (ms1_q == 16'd0) ? 16'd1 : ms1_q;
  assign prod_d = {16'd0, ramp_rate_q} * {17'd0, ms_eff};

  // stage 2: divide by 1000 as a shift by three and a reciprocal of 125
  logic [2:0]  req2_q, dir2_q;
  logic [6:0]  pct2_q;
  logic [32:0] prod_q;
  logic [60:0] quot_w;
  logic [23:0] quot;
  logic [14:0] step_d;

  assign quot_w = {31'd0, prod_q[32:3]} * {30'd0, ddsp_pkg::RECIP_125};
  assign quot   = quot_w[ddsp_pkg::RECIP_125_SHIFT +: 24];
  assign step_d = (quot > {9'd0, ddsp_pkg::STEP_MAX}) ? ddsp_pkg::STEP_MAX : quot[14:0];

  // stage 3: target and level update
  logic [2:0]         req3_q, dir3_q;
  logic [6:0]         pct3_q;
  logic [14:0]        step_q;
  logic signed [14:0] l_tgt_q, r_tgt_q, l_lvl_q, r_lvl_q;
  logic signed [14:0] l_tgt_d, r_tgt_d, l_lvl_d, r_lvl_d;
  logic               estop_q, estop_d;
  logic               upd;
  logic [6:0]         pct_sat;
  logic [13:0]        speed;
  logic signed [14:0] spd_pos, spd_neg;

  function automatic logic signed [14:0] slew_level(
    input logic signed [14:0] cur,
    input logic signed [14:0] tgt,
    input logic [14:0]        step
  );
    logic signed [16:0] cur_x, tgt_x, up, dn;
    logic signed [14:0] res;
    cur_x = {{2{cur[14]}}, cur};
    tgt_x = {{2{tgt[14]}}, tgt};
    up    = cur_x + $signed({2'b00, step});
    dn    = cur_x - $signed({2'b00, step});
    res   = cur;
    if (cur_x < tgt_x) begin
      res = (up > tgt_x) ? tgt : up[14:0];
    end else if (cur_x > tgt_x) begin
      res = (dn < tgt_x) ? tgt : dn[14:0];
    end
    return res;
  endfunction

  assign upd     = v3_q && rdy4;
  assign pct_sat = (pct3_q > ddsp_pkg::PCT_MAX) ? ddsp_pkg::PCT_MAX : pct3_q;
  assign speed   = 14'(pct_sat) * 14'd100;
  assign spd_pos = $signed({1'b0, speed});
  assign spd_neg = -spd_pos;

  always_comb begin
    l_tgt_d = l_tgt_q;
    r_tgt_d = r_tgt_q;
    l_lvl_d = l_lvl_q;
    r_lvl_d = r_lvl_q;
    estop_d = estop_q;
    case (ddsp_pkg::req_type_e'(req3_q))
      ddsp_pkg::REQ_DRIVE: begin
        case (ddsp_pkg::drive_dir_e'(dir3_q))
          ddsp_pkg::DIR_FWD: begin
            l_tgt_d = spd_pos;
            r_tgt_d = spd_pos;
          end
          ddsp_pkg::DIR_REV: begin
            l_tgt_d = spd_neg;
            r_tgt_d = spd_neg;
          end
          ddsp_pkg::DIR_SPIN_L: begin
            l_tgt_d = spd_neg;
            r_tgt_d = spd_pos;
          end
          ddsp_pkg::DIR_SPIN_R: begin
            l_tgt_d = spd_pos;
            r_tgt_d = spd_neg;
          end
          default: begin
            l_tgt_d = '0;
            r_tgt_d = '0;
          end
        endcase
        if (estop_q) begin
          l_tgt_d = '0;
          r_tgt_d = '0;
        end
      end
      ddsp_pkg::REQ_STOP, ddsp_pkg::REQ_ESTOP, ddsp_pkg::REQ_ENABLE: begin
        l_tgt_d = '0;
        r_tgt_d = '0;
        l_lvl_d = '0;
        r_lvl_d = '0;
        if (ddsp_pkg::req_type_e'(req3_q) == ddsp_pkg::REQ_ESTOP) estop_d = 1'b1;
        if (ddsp_pkg::req_type_e'(req3_q) == ddsp_pkg::REQ_ENABLE) estop_d = 1'b0;
      end
      ddsp_pkg::REQ_TICK: begin
        if (estop_q) begin
          l_lvl_d = '0;
          r_lvl_d = '0;
        end else begin
          l_lvl_d = slew_level(l_lvl_q, l_tgt_q, step_q);
          r_lvl_d = slew_level(r_lvl_q, r_tgt_q, step_q);
        end
      end
      default: begin
        estop_d = estop_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_tgt_q <= '0;
      r_tgt_q <= '0;
      l_lvl_q <= '0;
      r_lvl_q <= '0;
      estop_q <= 1'b0;
    end else if (upd) begin
      l_tgt_q <= l_tgt_d;
      r_tgt_q <= r_tgt_d;
      l_lvl_q <= l_lvl_d;
      r_lvl_q <= r_lvl_d;
      estop_q <= estop_d;
    end
  end

  // stage 4: level magnitude times full duty, plus half for rounding
  logic signed [14:0] l4_q, r4_q;
  logic               e4_q;
  logic [PW-1:0]      l_prod_d, r_prod_d;

  function automatic logic [13:0] level_mag(input logic signed [14:0] lvl);
    logic [15:0] mag_w;
    mag_w = lvl[14] ? 16'(-$signed({lvl[14], lvl})) : {1'b0, lvl};
    return (mag_w > 16'(ddsp_pkg::LEVEL_FULL)) ? 14'(ddsp_pkg::LEVEL_FULL) : mag_w[13:0];
  endfunction

  assign l_prod_d = PW'(level_mag(l4_q)) * PW'(DUTY_MAX) + PW'(ddsp_pkg::LEVEL_FULL / 2);
  assign r_prod_d = PW'(level_mag(r4_q)) * PW'(DUTY_MAX) + PW'(ddsp_pkg::LEVEL_FULL / 2);

  // stage 5: divide by 10000 as a shift by four and a reciprocal of 625
  logic signed [14:0] l5_q, r5_q;
  logic               e5_q;
  logic [PW-1:0]      l_prod_q, r_prod_q;
  logic [PRW-1:0]     l_quot_w, r_quot_w;
  logic [9:0]         l_duty, r_duty;

  assign l_quot_w = PRW'(l_prod_q[PW-1:4]) * PRW'(RECIP_625);
  assign r_quot_w = PRW'(r_prod_q[PW-1:4]) * PRW'(RECIP_625);
  assign l_duty   = l_quot_w[K2 +: 10];
  assign r_duty   = r_quot_w[K2 +: 10];

  // pipeline payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      req1_q <= req_type_i;
      dir1_q <= drive_dir_i;
      pct1_q <= speed_pct_i;
      ms1_q  <= elapsed_ms_i;
    end
    if (rdy2) begin
      req2_q <= req1_q;
      dir2_q <= dir1_q;
      pct2_q <= pct1_q;
      prod_q <= prod_d;
    end
    if (rdy3) begin
      req3_q <= req2_q;
      dir3_q <= dir2_q;
      pct3_q <= pct2_q;
      step_q <= step_d;
    end
    if (rdy4) begin
      l4_q <= l_lvl_d;
      r4_q <= r_lvl_d;
      e4_q <= estop_d;
    end
    if (rdy5) begin
      l5_q     <= l4_q;
      r5_q     <= r4_q;
      e5_q     <= e4_q;
      l_prod_q <= l_prod_d;
      r_prod_q <= r_prod_d;
    end
    if (out_rdy) begin
      left_fwd_duty_o  <= (l5_q > 15'sd0) ? l_duty : 10'd0;
      left_rev_duty_o  <= (l5_q < 15'sd0) ? l_duty : 10'd0;
      right_fwd_duty_o <= (r5_q > 15'sd0) ? r_duty : 10'd0;
      right_rev_duty_o <= (r5_q < 15'sd0) ? r_duty : 10'd0;
      left_now_o       <= l5_q;
      right_now_o      <= r5_q;
      estop_active_o   <= e5_q;
    end
  end

endmodule

[hdl/ddsp_checker.sv]
// ---------------------------------------------------------------------------
// ddsp_checker
// Port-level checks on the drive unit, attached by bind.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddsp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [9:0]         left_fwd_duty_o,
  input logic [9:0]         left_rev_duty_o,
  input logic [9:0]         right_fwd_duty_o,
  input logic [9:0]         right_rev_duty_o,
  input logic signed [14:0] left_now_o,
  input logic signed [14:0] right_now_o,
  input logic               estop_active_o
);

  // no result word while in reset
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

  // a stalled word stays put
  `ASSERT_CLK(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(left_now_o) && $stable(right_fwd_duty_o), "stalled result changed")

  // latched estop means both tracks at rest
  `ASSERT_CLK(a_estop_rest, clk_i, rst_ni, out_valid_o && estop_active_o |-> left_now_o == 15'sd0 && right_now_o == 15'sd0 && left_fwd_duty_o == 10'd0 && right_rev_duty_o == 10'd0, "level not zero under estop")

  // never both halves of a bridge at once
  `ASSERT_CLK(a_bridge_excl, clk_i, rst_ni, out_valid_o |-> (left_fwd_duty_o == 10'd0 || left_rev_duty_o == 10'd0) && (right_fwd_duty_o == 10'd0 || right_rev_duty_o == 10'd0), "both bridge halves driven")

  // duty side follows the sign of the level
  `ASSERT_CLK(a_duty_sign, clk_i, rst_ni, out_valid_o |-> (left_now_o > 15'sd0 || left_fwd_duty_o == 10'd0) && (right_now_o < 15'sd0 || right_rev_duty_o == 10'd0), "duty on wrong side of bridge")

endmodule

bind differential_drive_slew_pwm_unit ddsp_checker u_ddsp_checker (.*);

[test/tb_differential_drive_slew_pwm_unit.sv]
// ---------------------------------------------------------------------------
// tb_differential_drive_slew_pwm_unit
// Self-checking bench for the two-track slew and PWM unit. A table of
// hand-picked request words covers the extremes and every request and
// direction, including undefined codes. Random phases follow, each under its
// own ramp rate. A behavioural copy of the track logic predicts the result
// words the table leaves open; each is checked per field in order of arrival.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_differential_drive_slew_pwm_unit;
  import ddsp_pkg::*;

  localparam int PWM_FULL       = DUTY_MAX_DEF;
  localparam int PHASE_WORDS    = 240;
  localparam int CALM_WORDS     = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;

  // codes the block does not define
  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [2:0] DIR_UNUSED = 3'd5;

  typedef struct packed {
    logic [9:0]         lf;
    logic [9:0]         lr;
    logic [9:0]         rf;
    logic [9:0]         rr;
    logic signed [14:0] left_lvl;
    logic signed [14:0] right_lvl;
    logic               estop;
  } drive_status_t;

  typedef struct packed {
    logic [2:0]    req;
    logic [2:0]    dir;
    logic [6:0]    pct;
    logic [15:0]   ms;
    logic          known;
    drive_status_t want;
  } drive_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [2:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [2:0]         req_type_i;
  logic [2:0]         drive_dir_i;
  logic [6:0]         speed_pct_i;
  logic [15:0]        elapsed_ms_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [9:0]         left_fwd_duty_o;
  logic [9:0]         left_rev_duty_o;
  logic [9:0]         right_fwd_duty_o;
  logic [9:0]         right_rev_duty_o;
  logic signed [14:0] left_now_o;
  logic signed [14:0] right_now_o;
  logic               estop_active_o;

  // track state of the predictor
  int            lt_target;
  int            rt_target;
  int            lt_level;
  int            rt_level;
  logic          estop_latched;
  logic [16:0]   ramp_now;

  drive_status_t drive_status_q[$];
  drive_word_t   drive_plan[$];
  int            fault_count = 0;
  int            quiet_cycles = 0;
  int            hold_left = 0;
  logic          calm = 1'b0;

  differential_drive_slew_pwm_unit #(
    .DUTY_MAX(PWM_FULL)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .drive_dir_i     (drive_dir_i),
    .speed_pct_i     (speed_pct_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .left_fwd_duty_o (left_fwd_duty_o),
    .left_rev_duty_o (left_rev_duty_o),
    .right_fwd_duty_o(right_fwd_duty_o),
    .right_rev_duty_o(right_rev_duty_o),
    .left_now_o      (left_now_o),
    .right_now_o     (right_now_o),
    .estop_active_o  (estop_active_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // move a level toward its target without overshoot
  function automatic int slew_toward(int cur, int tgt, longint stepv);
    longint n;
    n = cur;
    if (cur < tgt) begin
      n = longint'(cur) + stepv;
      if (n > tgt) n = tgt;
    end else if (cur > tgt) begin
      n = longint'(cur) - stepv;
      if (n < tgt) n = tgt;
    end
    return int'(n);
  endfunction

  // rounded bridge duty for a level magnitude, halves away from zero
  function automatic logic [9:0] duty_of(int lvl);
    longint mag;
    longint d;
    mag = (lvl < 0) ? -lvl : lvl;
    if (mag > LEVEL_FULL) mag = LEVEL_FULL;
    d = (mag * PWM_FULL + 5000) / 10000;
    return d[9:0];
  endfunction

  // apply one request word to the track state and report the outcome
  function automatic drive_status_t step_drive(drive_word_t w);
    drive_status_t st;
    int            s;
    int            l;
    int            r;
    longint        msv;
    longint        stepv;
    l = 0;
    r = 0;
    case (w.req)
      REQ_DRIVE: begin
        s = ((w.pct > PCT_MAX) ? int'(PCT_MAX) : int'(w.pct)) * 100;
        case (w.dir)
          DIR_FWD: begin
            l = s;
            r = s;
          end
          DIR_REV: begin
            l = -s;
            r = -s;
          end
          DIR_SPIN_L: begin
            l = -s;
            r = s;
          end
          DIR_SPIN_R: begin
            l = s;
            r = -s;
          end
          default: begin
            l = 0;
            r = 0;
          end
        endcase
        if (estop_latched) begin
          l = 0;
          r = 0;
        end
        lt_target = l;
        rt_target = r;
      end
      REQ_STOP, REQ_ESTOP, REQ_ENABLE: begin
        lt_target = 0;
        rt_target = 0;
        lt_level  = 0;
        rt_level  = 0;
        if (w.req == REQ_ESTOP) estop_latched = 1'b1;
        if (w.req == REQ_ENABLE) estop_latched = 1'b0;
      end
      REQ_TICK: begin
        if (estop_latched) begin
          lt_level = 0;
          rt_level = 0;
        end else begin
          msv      = (w.ms == 16'd0) ? 1 : longint'(w.ms);
          stepv    = (longint'(ramp_now) * msv) / 1000;
          lt_level = slew_toward(lt_level, lt_target, stepv);
          rt_level = slew_toward(rt_level, rt_target, stepv);
        end
      end
      default: begin
      end
    endcase
    st.lf        = (lt_level > 0) ? duty_of(lt_level) : 10'd0;
    st.lr        = (lt_level < 0) ? duty_of(lt_level) : 10'd0;
    st.rf        = (rt_level > 0) ? duty_of(rt_level) : 10'd0;
    st.rr        = (rt_level < 0) ? duty_of(rt_level) : 10'd0;
    st.left_lvl  = lt_level[14:0];
    st.right_lvl = rt_level[14:0];
    st.estop     = estop_latched;
    return st;
  endfunction

  // one row of the directed table
  task automatic plan_row(input logic [2:0] req, input logic [2:0] dir,
                          input logic [6:0] pct, input logic [15:0] ms,
                          input logic known, input int lf, input int lr,
                          input int rf, input int rr, input int ln,
                          input int rn, input logic es);
    drive_word_t w;
    w.req            = req;
    w.dir            = dir;
    w.pct            = pct;
    w.ms             = ms;
    w.known          = known;
    w.want.lf        = lf[9:0];
    w.want.lr        = lr[9:0];
    w.want.rf        = rf[9:0];
    w.want.rr        = rr[9:0];
    w.want.left_lvl  = ln[14:0];
    w.want.right_lvl = rn[14:0];
    w.want.estop     = es;
    drive_plan.push_back(w);
  endtask

  // random request word, mostly drives and ticks with some noise
  function automatic drive_word_t random_word();
    drive_word_t w;
    int          pick;
    w      = '0;
    pick   = $urandom_range(0, 99);
    if (pick < 28)      w.req = REQ_DRIVE;
    else if (pick < 72) w.req = REQ_TICK;
    else if (pick < 78) w.req = REQ_STOP;
    else if (pick < 82) w.req = REQ_ESTOP;
    else if (pick < 90) w.req = REQ_ENABLE;
    else                w.req = 3'($urandom_range(0, 7));
    w.dir = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                        : 3'($urandom_range(0, 3));
    w.pct = 7'($urandom_range(0, 127));
    case ($urandom_range(0, 2))
      0:       w.ms = 16'($urandom_range(0, 20));
      1:       w.ms = 16'($urandom_range(0, 1500));
      default: w.ms = 16'($urandom_range(0, 65535));
    endcase
    return w;
  endfunction

  // present one word, with an optional gap, and wait for it to be taken
  task automatic send_word(input drive_word_t w);
    drive_status_t st;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= w.req;
    drive_dir_i  <= w.dir;
    speed_pct_i  <= w.pct;
    elapsed_ms_i <= w.ms;
    do @(posedge clk_i); while (in_stall_o);
    st = step_drive(w);
    drive_status_q.push_back(w.known ? w.want : st);
  endtask

  // write the ramp rate once the pipe has drained
  task automatic set_ramp(input logic [16:0] rate);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (drive_status_q.size() == 0);
    repeat (8) @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'({REG_RAMP_RATE, 2'b00});
    pwdata  <= 32'(rate);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ramp_now = rate;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic void match_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  // result stall in random bursts, none once calm
  always @(negedge clk_i) begin
    if (calm || !rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall_i <= 1'b1;
      hold_left = $urandom_range(1, 12) - 1;
    end else begin
      out_stall_i <= 1'b0;
      hold_left = $urandom_range(1, 20) - 1;
    end
  end

  // result word check and watchdog
  always @(posedge clk_i) begin : result_check
    drive_status_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (drive_status_q.size() == 0) begin
          $error("result word with nothing pending");
          fault_count++;
        end else begin
          want = drive_status_q.pop_front();
          match_field("left_fwd_duty", want.lf, left_fwd_duty_o);
          match_field("left_rev_duty", want.lr, left_rev_duty_o);
          match_field("right_fwd_duty", want.rf, right_fwd_duty_o);
          match_field("right_rev_duty", want.rr, right_rev_duty_o);
          match_field("left_now", want.left_lvl, left_now_o);
          match_field("right_now", want.right_lvl, right_now_o);
          match_field("estop_active", want.estop, estop_active_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    logic [16:0] ramp_plan [8];
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    req_type_i   <= REQ_TICK;
    drive_dir_i  <= DIR_NONE;
    speed_pct_i  <= '0;
    elapsed_ms_i <= '0;

    lt_target     = 0;
    rt_target     = 0;
    lt_level      = 0;
    rt_level      = 0;
    estop_latched = 1'b0;
    ramp_now      = RAMP_RATE_RST;

    ramp_plan[0] = 17'd0;
    ramp_plan[1] = 17'd100000;
    ramp_plan[2] = 17'h1FFFF;
    ramp_plan[3] = 17'd1;
    ramp_plan[4] = RAMP_RATE_RST;
    ramp_plan[5] = 17'($urandom_range(0, 100000));
    ramp_plan[6] = 17'($urandom_range(0, 3000));
    ramp_plan[7] = 17'($urandom_range(0, 100000));

    // directed table, reset ramp rate
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd0,     1, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_FWD,    7'd127, 16'd0,     1, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'hFFFF,  1, 1023, 0, 1023, 0,
             10000, 10000, 0);
    plan_row(REQ_DRIVE,  DIR_REV,    7'd100, 16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd1,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'hFFFF,  1, 0, 1023, 0, 1023,
             -10000, -10000, 0);
    plan_row(REQ_DRIVE,  DIR_SPIN_L, 7'd50,  16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd300,   0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_SPIN_R, 7'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd1000,  0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_NONE,   7'd80,  16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_UNUSED, 7'd90,  16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'hFFFF,  1, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_FWD,    7'd37,  16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd4000,  0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_STOP,   DIR_NONE,   7'd0,   16'd0,     1, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_FWD,    7'd100, 16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd2000,  1, 1023, 0, 1023, 0,
             10000, 10000, 0);
    plan_row(REQ_UNUSED, DIR_FWD,    7'd100, 16'd50,    0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_ESTOP,  DIR_NONE,   7'd0,   16'd0,     1, 0, 0, 0, 0, 0, 0, 1);
    plan_row(REQ_DRIVE,  DIR_FWD,    7'd100, 16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'hFFFF,  1, 0, 0, 0, 0, 0, 0, 1);
    plan_row(REQ_ENABLE, DIR_NONE,   7'd0,   16'd0,     1, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_DRIVE,  DIR_SPIN_R, 7'd1,   16'd0,     0, 0, 0, 0, 0, 0, 0, 0);
    plan_row(REQ_TICK,   DIR_NONE,   7'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0, 0);

    // hold reset, then release it
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (drive_plan[i]) send_word(drive_plan[i]);

    // random phases, one ramp rate each, the tail without idling
    foreach (ramp_plan[p]) begin
      set_ramp(ramp_plan[p]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 7 && n >= PHASE_WORDS - CALM_WORDS) calm = 1'b1;
        send_word(random_word());
      end
    end

    // drain
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (drive_status_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0 && drive_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/ddsp_pkg.sv
hdl/differential_drive_slew_pwm_unit.sv
hdl/ddsp_checker.sv
test/tb_differential_drive_slew_pwm_unit.sv
